[rtl/core/sxfb_pkg.sv]
`default_nettype none
package sxfb_pkg;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // leftmost sprite pixel
   localparam logic [7:0] SPRITE_MSB = 8'h80;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // latch the incoming word, start the row read
      logic commit;   // write back, update flags, load the result register
   } sxfb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rsp_full; // result register holds a word not yet taken
   } sxfb_sts_type;

endpackage
`default_nettype wire

[rtl/core/sprite_xor_framebuffer_core.sv]
`default_nettype none
// Monochrome XOR framebuffer of DISPLAY_WIDTH x DISPLAY_HEIGHT pixels. Each input word is
// one operation: clear screen, draw one 8-pixel sprite row (MSB leftmost, XORed in at
// x_base, row y_base+row_index, both wrapped), or read one pixel (wrapped). Every word gives
// exactly one result word: the sprite's accumulated collision flag (set when a draw turns a
// lit pixel off, cleared after a draw marked tlast is answered) and, for reads, the pixel.
// Each word passes a fetch step, reading the row from the row memory's registered read port,
// and a commit step, which modifies, writes back and loads the result register. Clear takes
// the same steps, since it drops per-row valid bits at once instead of sweeping the memory;
// reset clears the screen the same way. The result register lets the next word enter
// while a result waits; only a second result with the first still untaken stalls the core.
module sprite_xor_framebuffer_core #(
   parameter int DISPLAY_WIDTH  = 64,   // 8 .. 64
   parameter int DISPLAY_HEIGHT = 32    // 1 .. 64
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,  // operation[1:0], x_base[9:2], y_base[17:10],
                                   // row_index[21:18], sprite_row[29:22], zero[31:30]
   input  wire         req_tlast,  // last_row
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata   // collision[0], pixel[1], zero[7:2]
);
   import sxfb_pkg::*;

   sxfb_cmd_type cmd;
   sxfb_sts_type sts;
   logic         coll;
   logic         pix;

   sxfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sxfb_datapath #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .operation     (req_tdata[1:0]),
      .x_base        (req_tdata[9:2]),
      .y_base        (req_tdata[17:10]),
      .row_index     (req_tdata[21:18]),
      .sprite_row    (req_tdata[29:22]),
      .last_row      (req_tlast),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_collision (coll),
      .rsp_pixel     (pix)
   );

   assign rsp_tdata = {6'd0, pix, coll};

endmodule
`default_nettype wire

[rtl/core/sxfb_ctrl.sv]
`default_nettype none
module sxfb_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire                      rsp_tready,
   input  sxfb_pkg::sxfb_sts_type   sts,
   output sxfb_pkg::sxfb_cmd_type   cmd
);
   import sxfb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.accept = req_tvalid && req_tready;
      // hold in EXEC while the previous result is still waiting
      cmd.commit = (state_ff == ST_EXEC) && (!sts.rsp_full || rsp_tready);
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/sxfb_datapath.sv]
`default_nettype none
module sxfb_datapath #(
   parameter int DISPLAY_WIDTH  = 64,
   parameter int DISPLAY_HEIGHT = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  sxfb_pkg::sxfb_cmd_type   cmd,
   output sxfb_pkg::sxfb_sts_type   sts,
   input  wire [1:0]                operation,
   input  wire [7:0]                x_base,
   input  wire [7:0]                y_base,
   input  wire [3:0]                row_index,
   input  wire [7:0]                sprite_row,
   input  wire                      last_row,
   input  wire                      rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     rsp_collision,
   output logic                     rsp_pixel
);
   import sxfb_pkg::*;

   localparam int XW = $clog2(DISPLAY_WIDTH);
   localparam int AW = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;

   // modulo tables, built at elaboration
   logic [XW-1:0] x_mod_tbl [256];
   logic [AW-1:0] y_mod_tbl [256];

   for (genvar i = 0; i < 256; i++) begin : g_mod
      localparam int XM = i % DISPLAY_WIDTH;
      localparam int YM = i % DISPLAY_HEIGHT;
      assign x_mod_tbl[i] = XW'(XM);
      assign y_mod_tbl[i] = AW'(YM);
   end

   // row store, one word per display row
   logic [DISPLAY_WIDTH-1:0]  frame_mem_ff [DISPLAY_HEIGHT];
   logic [DISPLAY_HEIGHT-1:0] row_valid_ff;
   logic [DISPLAY_HEIGHT-1:0] row_valid_in;

   logic [DISPLAY_WIDTH-1:0]  rd_row_ff;
   logic                      rd_valid_ff;

   // latched item
   logic [1:0]    op_ff;
   logic [XW-1:0] xw_ff;
   logic [AW-1:0] addr_ff;
   logic [7:0]    sprite_ff;
   logic          last_ff;

   logic          hit_ff;
   logic          hit_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          coll_ff;
   logic          pix_ff;

   logic [AW:0]   y_sum;
   logic [AW-1:0] addr_in;
   logic [XW:0]   xc;
   logic [DISPLAY_WIDTH-1:0] row_cur;
   logic [DISPLAY_WIDTH-1:0] mask;
   logic [DISPLAY_WIDTH-1:0] new_row;
   logic          erase;
   logic          coll_in;
   logic          pix_in;

   // row address: wrapped y, plus wrapped row index for draws
   always_comb begin
      y_sum = (AW+1)'(y_mod_tbl[y_base]) + (AW+1)'(y_mod_tbl[{4'd0, row_index}]);
      if (y_sum >= (AW+1)'(DISPLAY_HEIGHT)) y_sum = y_sum - (AW+1)'(DISPLAY_HEIGHT);
      if (operation == OP_DRAW) addr_in = y_sum[AW-1:0];
      else                      addr_in = y_mod_tbl[y_base];
   end

   // XOR of the sprite byte into the fetched row
   always_comb begin
      row_cur = rd_valid_ff ? rd_row_ff : '0;
      mask    = '0;
      xc      = '0;
      for (int c = 0; c < 8; c++) begin
         xc = (XW+1)'(xw_ff) + (XW+1)'(c);
         if (xc >= (XW+1)'(DISPLAY_WIDTH)) xc = xc - (XW+1)'(DISPLAY_WIDTH);
         if ((8'(sprite_ff << c) & SPRITE_MSB) != 8'd0) mask[xc[XW-1:0]] = 1'b1;
      end
      new_row = row_cur ^ mask;
      erase   = |(row_cur & mask);
   end

   always_comb begin
      hit_in       = hit_ff;
      coll_in      = hit_ff;
      pix_in       = 1'b0;
      row_valid_in = row_valid_ff;
      case (op_ff)
         OP_CLEAR: row_valid_in = '0;
         OP_DRAW: begin
            coll_in               = hit_ff | erase;
            hit_in                = last_ff ? 1'b0 : (hit_ff | erase);
            row_valid_in[addr_ff] = 1'b1;
         end
         OP_READ: pix_in = row_cur[xw_ff];
         default: ;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.commit)                 rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            row_valid_ff <= row_valid_in;
            hit_ff       <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= operation;
         xw_ff       <= x_mod_tbl[x_base];
         addr_ff     <= addr_in;
         sprite_ff   <= sprite_row;
         last_ff     <= last_row;
         rd_row_ff   <= frame_mem_ff[addr_in];
         rd_valid_ff <= row_valid_ff[addr_in];
      end
      if (cmd.commit) begin
         coll_ff <= coll_in;
         pix_ff  <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (op_ff == OP_DRAW)) frame_mem_ff[addr_ff] <= new_row;
   end

   assign sts.rsp_full  = rsp_valid_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_collision = coll_ff;
   assign rsp_pixel     = pix_ff;

endmodule
`default_nettype wire

[tb/sxfb_frame_checker.sv]
`timescale 1ns / 1ps
module sxfb_frame_checker #(
   parameter int DISPLAY_WIDTH  = 64,
   parameter int DISPLAY_HEIGHT = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,  // operation[1:0], x_base[9:2], y_base[17:10],
                                   // row_index[21:18], sprite_row[29:22], zero[31:30]
   input  wire         req_tlast,  // last_row
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [7:0]  rsp_tdata,  // collision[0], pixel[1], zero[7:2]
   output int          fail_count,
   output int          pending_count
);
   import sxfb_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic collision;
      logic pixel;
   } pixel_result_type;

   logic [63:0]      frame_bits [0:DISPLAY_HEIGHT-1];
   logic             sprite_hit;
   pixel_result_type result_queue [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < PRINT_CAP)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // applies one word to the model screen and returns the result word it causes
   function automatic pixel_result_type apply_word(input logic [31:0] data, input logic last);
      logic [1:0]       op;
      int unsigned      xb, yb, ri, row_y, col_x;
      int               col;
      logic [7:0]       bits;
      logic [63:0]      row;
      pixel_result_type res;
      op   = data[1:0];
      xb   = data[9:2];
      yb   = data[17:10];
      ri   = data[21:18];
      bits = data[29:22];
      res  = '0;
      case (op)
         OP_CLEAR: begin
            foreach (frame_bits[i]) frame_bits[i] = '0;
         end
         OP_DRAW: begin
            row_y = (yb + ri) % DISPLAY_HEIGHT;
            row   = frame_bits[row_y];
            for (col = 0; col < 8; col++) begin
               col_x = (xb + col) % DISPLAY_WIDTH;
               if (((bits << col) & SPRITE_MSB) != 8'd0) begin
                  if (row[col_x]) sprite_hit = 1'b1;
                  row[col_x] = ~row[col_x];
               end
            end
            frame_bits[row_y] = row;
         end
         OP_READ: begin
            res.pixel = frame_bits[yb % DISPLAY_HEIGHT][xb % DISPLAY_WIDTH];
         end
         default: begin
         end
      endcase
      res.collision = sprite_hit;
      // flag is answered with the last row, then dropped
      if (op == OP_DRAW && last) sprite_hit = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         foreach (frame_bits[i]) frame_bits[i] = '0;
         sprite_hit = 1'b0;
      end else begin
         // pop before push: a word's result can never leave on its own accept edge
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               report_mismatch("unexpected result word, tdata", rsp_tdata, 0);
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[0] !== want.collision)
                  report_mismatch("collision", rsp_tdata[0], want.collision);
               if (rsp_tdata[1] !== want.pixel)
                  report_mismatch("pixel", rsp_tdata[1], want.pixel);
               if (rsp_tdata[7:2] !== 6'd0)
                  report_mismatch("pad bits", rsp_tdata[7:2], 0);
            end
         end
         if (req_tvalid && req_tready)
            result_queue.push_back(apply_word(req_tdata, req_tlast));
      end
      pending_count <= result_queue.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import sxfb_pkg::*;

   localparam int DISPLAY_WIDTH  = 64;
   localparam int DISPLAY_HEIGHT = 32;

   // code 3 is not assigned; the core must answer it and change nothing
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 750;   // stop sending after about this many words
   localparam int CALM_WORDS   = 120;   // final stretch with no idling on either side
   localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES = 20;    // settle time after the last result

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // operation[1:0], x_base[9:2], y_base[17:10],
                                   // row_index[21:18], sprite_row[29:22], zero[31:30]
   logic        req_tlast  = 1'b0; // last_row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // collision[0], pixel[1], zero[7:2]

   int fail_count;
   int pending_count;
   int quiet_cycles = 0;
   int words_sent   = 0;
   bit idle_on      = 1'b1;        // random idle bursts allowed on both channels

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sprite_xor_framebuffer_core #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sxfb_frame_checker #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) frame_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // result side: stall in bursts of random length while idling is on
   always begin
      @(posedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // watchdog: no handshake on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request word; returns at the edge where it is taken.
   // valid stays high into the next word unless an idle burst is drawn.
   task automatic send_word(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                            input logic [3:0] ri, input logic [7:0] bits, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, bits, ri, y, x, op};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // a whole sprite: rows 0..n-1 in order, tlast on the final one
   task automatic send_sprite(input logic [7:0] x, input logic [7:0] y, input int rows);
      int r;
      for (r = 0; r < rows; r++)
         send_word(OP_DRAW, x, y, r[3:0], 8'($urandom_range(0, 255)), r == rows - 1);
   endtask

   initial begin
      int          pick;
      logic [7:0]  px, py;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed words ----
      send_word(OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0); // blank screen after reset
      send_word(OP_DRAW,  8'd0,   8'd0,   4'd0,  8'hFF, 1'b0); // full byte on row 0
      send_word(OP_DRAW,  8'd0,   8'd0,   4'd1,  8'h80, 1'b1); // only the leftmost bit
      send_word(OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
      send_word(OP_READ,  8'd7,   8'd0,   4'd0,  8'h00, 1'b0);
      send_word(OP_READ,  8'd8,   8'd0,   4'd0,  8'h00, 1'b0);
      send_word(OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h81, 1'b0); // erases two lit pixels
      send_word(OP_DRAW,  8'd16,  8'd0,   4'd1,  8'h01, 1'b1); // flag held through last row
      send_word(OP_READ,  8'd0,   8'd1,   4'd0,  8'h00, 1'b1); // tlast outside a draw
      send_word(OP_DRAW,  8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1); // both coordinates wrap
      send_word(OP_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0);
      send_word(OP_READ,  8'd255, 8'd46,  4'd0,  8'h00, 1'b0); // read wraps as well
      send_word(OP_READ,  8'd198, 8'd238, 4'd0,  8'h00, 1'b0);
      send_word(OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b1); // empty sprite row
      send_word(OP_UNUSED, 8'hFF, 8'hFF,  4'hF,  8'hFF, 1'b1); // unassigned code
      send_word(OP_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 1'b1);
      send_word(OP_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0);
      send_word(OP_DRAW,  8'd60,  8'd31,  4'd0,  8'h55, 1'b0); // wraps at the right edge
      send_word(OP_DRAW,  8'd60,  8'd31,  4'd0,  8'h55, 1'b1); // same again: erase all
      send_word(OP_DRAW,  8'hAA,  8'h55,  4'hA,  8'hAA, 1'b0);
      send_word(OP_DRAW,  8'hAA,  8'h55,  4'hA,  8'hAA, 1'b0); // sets the flag mid sprite
      send_word(OP_CLEAR, 8'h55,  8'hAA,  4'h5,  8'h55, 1'b0); // clear keeps the flag
      send_word(OP_READ,  8'hAA,  8'h55,  4'h0,  8'h00, 1'b0);
      send_word(OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b1); // answers and drops it

      // ---- random words ----
      // mostly whole sprites with random bytes; half land in a small corner so
      // they overlap and collide. Reads probe the same corner often.
      while (words_sent < RANDOM_WORDS) begin
         if (words_sent >= RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 1) == 0) begin
            px = 8'($urandom_range(0, 15));
            py = 8'($urandom_range(0, 7));
         end else begin
            px = 8'($urandom_range(0, 255));
            py = 8'($urandom_range(0, 255));
         end
         if (pick < 55) begin
            send_sprite(px, py, $urandom_range(0, 3) == 0 ? 16 : $urandom_range(1, 15));
         end else if (pick < 85) begin
            send_word(OP_READ, px, py, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 91) begin
            // stray row with random index and random tlast
            send_word(OP_DRAW, px, py, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 94) begin
            send_word(OP_CLEAR, px, py, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            send_word(OP_UNUSED, px, py, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
      req_tvalid <= 1'b0;

      // pending count is a registered copy of the queue size, so it lags the handshake
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/sxfb_pkg.sv
rtl/core/sxfb_ctrl.sv
rtl/core/sxfb_datapath.sv
rtl/core/sprite_xor_framebuffer_core.sv
tb/sxfb_frame_checker.sv
tb/testbench.sv
